// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the string run extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define PSRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is active.
`define PSRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PSRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/psre_pkg.sv =====
// Types, constants and helpers of the printable string run extractor.
`default_nettype none
package psre_pkg;

    localparam int OFFSET_BITS   = 32;
    localparam int OUT_BITS      = 32;
    localparam int OFS_EXT       = (OFFSET_BITS > OUT_BITS) ? OFFSET_BITS : OUT_BITS;
    localparam int MIN_LEN_BITS  = 16;
    localparam int DATA_BITS     = 8;
    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;
    localparam int N_SLOTS       = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MIN_LEN_BITS-1:0] MIN_LEN_RESET = 16'd8;

    // Register index decode: byte address bit 2 selects the 32-bit word.
    localparam logic CFG_IDX_MIN_LENGTH = 1'b0;

    // Result kind codes.
    localparam logic KIND_NARROW = 1'b0;
    localparam logic KIND_WIDE   = 1'b1;

    // Character class bounds.
    localparam logic [DATA_BITS-1:0] CHR_LO        = 8'h20;
    localparam logic [DATA_BITS-1:0] CHR_NARROW_HI = 8'h7F;
    localparam logic [DATA_BITS-1:0] CHR_WIDE_END  = 8'h7E;

    // Result slots, in report order.
    localparam int SLOT_NARROW_BREAK = 0;
    localparam int SLOT_NARROW_END   = 1;
    localparam int SLOT_WIDE_BREAK   = 2;
    localparam int SLOT_WIDE_END     = 3;

    typedef logic [OFFSET_BITS-1:0]  t_ofs;
    typedef logic [MIN_LEN_BITS-1:0] t_min_len;

    typedef struct packed {
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
    } t_slot;

    // All results caused by one input byte.
    typedef struct packed {
        logic [N_SLOTS-1:0]    mask;
        t_slot [N_SLOTS-1:0]   slot;
    } t_bundle;

    // Front to queue write side.
    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_qwr;

    // Queue read side to back.
    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_qrd;

    // Low output bits of an offset or length.
    function automatic logic [OUT_BITS-1:0] to_out(input t_ofs v);
        logic [OFS_EXT-1:0] ext;
        ext = OFS_EXT'(v);
        return ext[OUT_BITS-1:0];
    endfunction

    // Run length meets the minimum.
    function automatic logic len_ok(input t_ofs len, input t_min_len min_len);
        return OFS_EXT'(len) >= OFS_EXT'(min_len);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/psre_if.sv =====
// Byte input and run result channel interfaces.
`default_nettype none
interface psre_byte_if;
    import psre_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_byte;
    logic                 end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface psre_run_if;
    import psre_pkg::*;
    logic                valid;
    logic                ready;
    logic                run_kind;
    logic [OUT_BITS-1:0] run_start;
    logic [OUT_BITS-1:0] run_length;
    logic                last_of_run;

    modport source (output valid, output run_kind, output run_start, output run_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input run_kind, input run_start, input run_length,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/printable_string_run_extractor.sv =====
// Printable string run extractor: configuration register and front/queue/back assembly.
//
// Usage:
//   i_byte carries one buffer byte per transaction (data_byte, end_of_buffer on the final
//   byte). o_run carries one run per transaction: run_kind (0 narrow, 1 wide UTF-16LE),
//   run_start, run_length, and last_of_run on the final run caused by a given byte.
//   Runs of one byte come out in order: narrow break, narrow end of buffer, wide break,
//   wide end of buffer. Only runs at least min_length characters long are reported.
//   min_length sits at APB byte address 0 (reset 8); write it only while the block is idle.
// Timing:
//   The front end takes one byte per cycle while the queue is not full. A result passes
//   through the queue, the back end's bundle register and the output register to o_run;
//   results leave one per cycle unless o_run stalls, and a four-bundle queue absorbs bursts.
// Reset and stall:
//   Synchronous active-low reset clears the run trackers, queue and output register and
//   loads min_length with 8. When o_run is stalled the output register holds its result;
//   the queue keeps filling and i_byte.ready drops only when the queue is full.
`default_nettype none
module printable_string_run_extractor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [psre_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [psre_pkg::PDATA_BITS-1:0]  pwdata,
    output logic      [psre_pkg::PDATA_BITS-1:0]  prdata,
    output logic                                  pready,
    psre_byte_if.sink                             i_byte,
    psre_run_if.source                            o_run
);
    import psre_pkg::*;

    t_min_len r_min_length;
    logic     cfg_wr, q_ready, q_pop;
    t_qwr     qwr;
    t_qrd     qrd;

    // Configuration register write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MIN_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LEN_RESET;
        end else if (cfg_wr) begin
            r_min_length <= pwdata[MIN_LEN_BITS-1:0];
        end
    end

    // Read back.
    assign prdata = (paddr[2] == CFG_IDX_MIN_LENGTH) ? PDATA_BITS'(r_min_length) : '0;

    psre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_length (r_min_length),
        .i_byte       (i_byte),
        .i_q_ready    (q_ready),
        .o_qwr        (qwr)
    );

    psre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .o_ready (q_ready),
        .o_qrd   (qrd),
        .i_pop   (q_pop)
    );

    psre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qrd   (qrd),
        .o_pop   (q_pop),
        .o_run   (o_run)
    );

endmodule
`default_nettype wire

// ===== rtl/core/psre_front.sv =====
// Front end: tracks narrow and wide runs and builds one result bundle per byte.
`default_nettype none
`include "assert_macros.svh"
module psre_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psre_pkg::t_min_len i_min_length,
    psre_byte_if.sink              i_byte,
    input  wire logic              i_q_ready,
    output psre_pkg::t_qwr         o_qwr
);
    import psre_pkg::*;

    t_ofs                 r_byte_index, n_byte_index;
    t_ofs                 r_narrow_start, n_narrow_start;
    t_ofs                 r_wide_start, n_wide_start;
    logic [DATA_BITS-1:0] r_held_low_byte, n_held_low_byte;

    logic                 accept;
    logic [DATA_BITS-1:0] b;
    t_ofs                 idx, idx_p1, word_idx, words;
    t_ofs                 ns1, ws1;
    t_ofs                 len_nb, len_ne, len_wb, len_we;
    logic                 odd, narrow_print, wide_print, wide_break;
    t_bundle              bundle;

    assign i_byte.ready = i_q_ready;
    assign accept       = i_byte.valid && i_q_ready;
    assign b            = i_byte.data_byte;

    // Classify the byte and compute run lengths.
    always_comb begin
        idx          = r_byte_index;
        idx_p1       = idx + t_ofs'(1);
        odd          = idx[0];
        narrow_print = (b >= CHR_LO) && (b <= CHR_NARROW_HI);
        word_idx     = {1'b0, idx[OFFSET_BITS-1:1]};
        words        = word_idx + t_ofs'(odd);
        wide_print   = (b == '0) && (r_held_low_byte >= CHR_LO) &&
                       (r_held_low_byte < CHR_WIDE_END);
        wide_break   = odd && !wide_print;

        len_nb = idx - r_narrow_start;
        ns1    = narrow_print ? r_narrow_start : idx_p1;
        len_ne = idx_p1 - ns1;
        len_wb = word_idx - r_wide_start;
        ws1    = wide_break ? (word_idx + t_ofs'(1)) : r_wide_start;
        len_we = words - ws1;

        bundle.mask[SLOT_NARROW_BREAK] = !narrow_print && len_ok(len_nb, i_min_length);
        bundle.mask[SLOT_NARROW_END]   = i_byte.end_of_buffer && len_ok(len_ne, i_min_length);
        bundle.mask[SLOT_WIDE_BREAK]   = wide_break && len_ok(len_wb, i_min_length);
        bundle.mask[SLOT_WIDE_END]     = i_byte.end_of_buffer &&
                                         len_ok(len_we, i_min_length) && (words > ws1);

        bundle.slot[SLOT_NARROW_BREAK].start  = to_out(r_narrow_start);
        bundle.slot[SLOT_NARROW_BREAK].length = to_out(len_nb);
        bundle.slot[SLOT_NARROW_END].start    = to_out(ns1);
        bundle.slot[SLOT_NARROW_END].length   = to_out(len_ne);
        bundle.slot[SLOT_WIDE_BREAK].start    = to_out(r_wide_start);
        bundle.slot[SLOT_WIDE_BREAK].length   = to_out(len_wb);
        bundle.slot[SLOT_WIDE_END].start      = to_out(ws1);
        bundle.slot[SLOT_WIDE_END].length     = to_out(len_we);
    end

    // Push only bytes that cause at least one result.
    assign o_qwr.push   = accept && (bundle.mask != '0);
    assign o_qwr.bundle = bundle;

    // Advance tracker state; clear it at the end of a buffer.
    always_comb begin
        n_byte_index    = r_byte_index;
        n_narrow_start  = r_narrow_start;
        n_wide_start    = r_wide_start;
        n_held_low_byte = r_held_low_byte;
        if (accept) begin
            if (i_byte.end_of_buffer) begin
                n_byte_index    = '0;
                n_narrow_start  = '0;
                n_wide_start    = '0;
                n_held_low_byte = '0;
            end else begin
                n_byte_index    = idx_p1;
                n_narrow_start  = ns1;
                n_wide_start    = ws1;
                n_held_low_byte = odd ? r_held_low_byte : b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index    <= '0;
            r_narrow_start  <= '0;
            r_wide_start    <= '0;
            r_held_low_byte <= '0;
        end else begin
            r_byte_index    <= n_byte_index;
            r_narrow_start  <= n_narrow_start;
            r_wide_start    <= n_wide_start;
            r_held_low_byte <= n_held_low_byte;
        end
    end

    `PSRE_ASSERT_NXT(a_eob_clears_index, i_clk, i_rst_n, accept && i_byte.end_of_buffer, r_byte_index == '0)

endmodule
`default_nettype wire

// ===== rtl/core/psre_queue.sv =====
// Short bundle queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"
module psre_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire psre_pkg::t_qwr i_qwr,
    output logic                o_ready,
    output psre_pkg::t_qrd      o_qrd,
    input  wire logic           i_pop
);
    import psre_pkg::*;

    t_bundle                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count, n_count;
    logic                   do_push, do_pop;

    assign o_ready      = r_count != QCNT_BITS'(QUEUE_DEPTH);
    assign o_qrd.valid  = r_count != '0;
    assign o_qrd.bundle = r_mem[r_rd_ptr];
    assign do_push      = i_qwr.push && o_ready;
    assign do_pop       = i_pop && o_qrd.valid;

    // Advance pointers and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed bundles.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_qwr.bundle;
        end
    end

    `PSRE_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, !o_ready, !i_qwr.push)
    `PSRE_ASSERT_IMP(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, o_qrd.valid)
    `PSRE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_BITS'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// ===== rtl/core/psre_back.sv =====
// Back end: drains bundles one result per cycle into the output register while o_run is not stalled.
`default_nettype none
`include "assert_macros.svh"
module psre_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire psre_pkg::t_qrd i_qrd,
    output logic                o_pop,
    psre_run_if.source          o_run
);
    import psre_pkg::*;

    logic [N_SLOTS-1:0]  r_mask, n_mask;
    t_slot [N_SLOTS-1:0] r_slot;
    logic                r_out_valid, n_out_valid;
    logic                r_kind, r_last;
    logic [OUT_BITS-1:0] r_start, r_length;

    logic                adv, load, sel_last;
    logic [1:0]          sel;
    logic [N_SLOTS-1:0]  sel_hot, mask_after;

    assign adv  = !r_out_valid || o_run.ready;
    assign load = adv && (r_mask != '0);

    // Pick the earliest pending result.
    always_comb begin
        if (r_mask[SLOT_NARROW_BREAK]) begin
            sel = 2'(SLOT_NARROW_BREAK);
        end else if (r_mask[SLOT_NARROW_END]) begin
            sel = 2'(SLOT_NARROW_END);
        end else if (r_mask[SLOT_WIDE_BREAK]) begin
            sel = 2'(SLOT_WIDE_BREAK);
        end else begin
            sel = 2'(SLOT_WIDE_END);
        end
        sel_hot    = N_SLOTS'(1) << sel;
        mask_after = load ? (r_mask & ~sel_hot) : r_mask;
        sel_last   = (r_mask & ~sel_hot) == '0;
    end

    // Fetch the next bundle once the current one is used up.
    assign o_pop = (mask_after == '0) && i_qrd.valid;

    always_comb begin
        n_mask      = o_pop ? i_qrd.bundle.mask : mask_after;
        n_out_valid = load ? 1'b1 : (adv ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload of the current bundle and the output register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_slot <= i_qrd.bundle.slot;
        end
        if (load) begin
            r_kind   <= (sel >= 2'(SLOT_WIDE_BREAK)) ? KIND_WIDE : KIND_NARROW;
            r_start  <= r_slot[sel].start;
            r_length <= r_slot[sel].length;
            r_last   <= sel_last;
        end
    end

    assign o_run.valid       = r_out_valid;
    assign o_run.run_kind    = r_kind;
    assign o_run.run_start   = r_start;
    assign o_run.run_length  = r_length;
    assign o_run.last_of_run = r_last;

    `PSRE_ASSERT_NXT(a_more_after_not_last, i_clk, i_rst_n, load && !sel_last, r_mask != '0)
    `PSRE_ASSERT_IMP(a_pop_only_when_drained, i_clk, i_rst_n, o_pop, mask_after == '0)

endmodule
`default_nettype wire
